### rtl/mmq_pkg.sv
// Shared types and constants for the multi-mailbox message queue.
// Used by the controller, result stage, top level, checker and bench; depends on nothing.
package mmq_pkg;

   localparam int MAILBOXES_DEF     = 16;
   localparam int QUEUE_DEPTH_DEF   = 8;
   localparam int PAYLOAD_BYTES_DEF = 8;

   localparam int SENDER_W = 8;
   localparam int TYPE_W   = 32;
   localparam int SIZE_W   = 4;
   localparam int HDR_W    = SENDER_W + TYPE_W + SIZE_W;

   typedef enum logic [1:0] {
      FUNC_SEND    = 2'd0,
      FUNC_RECEIVE = 2'd1,
      FUNC_WAKEUP  = 2'd2,
      FUNC_CLEAR   = 2'd3
   } mmq_func_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_SLOT   = 3'd1,
      ST_TOO_LARGE  = 3'd2,
      ST_FULL       = 3'd3,
      ST_EMPTY      = 3'd4,
      ST_WOKEN      = 3'd5,
      ST_TERMINATED = 3'd6
   } mmq_status_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  mailbox_slot;
      logic [7:0]  sender_id;
      logic [31:0] msg_type;
      logic [7:0]  msg_size;
      logic [63:0] payload;
      logic        target_blocked;
      logic        receiver_terminated;
   } mmq_item_type;

   typedef struct packed {
      mmq_status_type status;
      logic           push;
      logic           pop;
      logic           notify;
   } mmq_op_type;

endpackage

### rtl/mmq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on nothing; used by the top level.
interface mmq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [7:0]  mailbox_slot;
   logic [7:0]  sender_id;
   logic [31:0] msg_type;
   logic [7:0]  msg_size;
   logic [63:0] payload;
   logic        target_blocked;
   logic        receiver_terminated;

   modport source (output valid, func, mailbox_slot, sender_id, msg_type, msg_size,
                   payload, target_blocked, receiver_terminated, input ready);
   modport sink (input valid, func, mailbox_slot, sender_id, msg_type, msg_size,
                 payload, target_blocked, receiver_terminated, output ready);
endinterface

interface mmq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  out_sender;
   logic [31:0] out_type;
   logic [3:0]  out_size;
   logic [63:0] out_payload;
   logic        notify;

   modport source (output valid, status, out_sender, out_type, out_size, out_payload,
                   notify, input ready);
   modport sink (input valid, status, out_sender, out_type, out_size, out_payload,
                 notify, output ready);
endinterface

### rtl/mmq_ctrl.sv
// Per-slot ring pointers and the decision logic for one operation.
// Depends on mmq_pkg.
module mmq_ctrl #(
   parameter int MAILBOXES     = mmq_pkg::MAILBOXES_DEF,
   parameter int QUEUE_DEPTH   = mmq_pkg::QUEUE_DEPTH_DEF,
   parameter int PAYLOAD_BYTES = mmq_pkg::PAYLOAD_BYTES_DEF,
   localparam int SLOT_W  = (MAILBOXES > 1) ? $clog2(MAILBOXES) : 1,
   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1),
   localparam int STORE_D = MAILBOXES * QUEUE_DEPTH,
   localparam int IDX_W   = (STORE_D > 1) ? $clog2(STORE_D) : 1,
   localparam int DATA_W  = 8 * PAYLOAD_BYTES,
   localparam int WORD_W  = mmq_pkg::HDR_W + DATA_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 go,
   input  mmq_pkg::mmq_item_type item,
   input  logic [31:0]          wakeup_type,
   output mmq_pkg::mmq_op_type  op,
   output logic [IDX_W-1:0]     wr_idx,
   output logic [IDX_W-1:0]     rd_idx,
   output logic [WORD_W-1:0]    wr_word
);

   logic [PTR_W-1:0] head_ff [MAILBOXES];
   logic [PTR_W-1:0] tail_ff [MAILBOXES];
   logic [CNT_W-1:0] count_ff [MAILBOXES];

   logic [SLOT_W-1:0] sidx;
   logic [PTR_W-1:0]  head;
   logic [PTR_W-1:0]  tail;
   logic [CNT_W-1:0]  count;
   logic              slot_ok;
   logic              full;
   logic              clr;
   logic [DATA_W-1:0] send_data;

   assign sidx    = item.mailbox_slot[SLOT_W-1:0];
   assign slot_ok = {1'b0, item.mailbox_slot} < 9'(MAILBOXES);
   assign head    = head_ff[sidx];
   assign tail    = tail_ff[sidx];
   assign count   = count_ff[sidx];
   assign full    = (count == CNT_W'(QUEUE_DEPTH));

   assign wr_idx = IDX_W'(32'(sidx) * QUEUE_DEPTH + 32'(tail));
   assign rd_idx = IDX_W'(32'(sidx) * QUEUE_DEPTH + 32'(head));

   always_comb begin
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         send_data[8*i +: 8] = (8'(i) < item.msg_size) ? item.payload[8*i +: 8] : 8'h00;
      end
   end

   always_comb begin
      op.status = mmq_pkg::ST_OK;
      op.push   = 1'b0;
      op.pop    = 1'b0;
      op.notify = 1'b0;
      clr       = 1'b0;
      wr_word   = {item.sender_id, item.msg_type, item.msg_size[3:0], send_data};
      priority if (!slot_ok) begin
         op.status = mmq_pkg::ST_BAD_SLOT;
      end else begin
         unique case (mmq_pkg::mmq_func_type'(item.func))
            mmq_pkg::FUNC_SEND: begin
               priority if (item.msg_size > 8'(PAYLOAD_BYTES)) begin
                  op.status = mmq_pkg::ST_TOO_LARGE;
               end else if (full) begin
                  op.status = mmq_pkg::ST_FULL;
               end else begin
                  op.push   = 1'b1;
                  op.notify = item.target_blocked;
               end
            end
            mmq_pkg::FUNC_RECEIVE: begin
               priority if (item.receiver_terminated) begin
                  op.status = mmq_pkg::ST_TERMINATED;
               end else if (count == '0) begin
                  op.status = mmq_pkg::ST_EMPTY;
               end else begin
                  op.pop = 1'b1;
               end
            end
            mmq_pkg::FUNC_WAKEUP: begin
               wr_word = {8'h00, wakeup_type, 4'h0, {DATA_W{1'b0}}};
               if (full) begin
                  op.status = mmq_pkg::ST_FULL;
               end else begin
                  op.push   = 1'b1;
                  op.notify = item.target_blocked;
               end
            end
            mmq_pkg::FUNC_CLEAR: begin
               clr = 1'b1;
            end
            default: begin
               op.status = mmq_pkg::ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < MAILBOXES; s++) begin
            head_ff[s]  <= '0;
            tail_ff[s]  <= '0;
            count_ff[s] <= '0;
         end
      end else if (go) begin
         if (op.push) begin
            tail_ff[sidx]  <= (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
            count_ff[sidx] <= count + 1'b1;
         end
         if (op.pop) begin
            head_ff[sidx]  <= (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            count_ff[sidx] <= count - 1'b1;
         end
         if (clr) begin
            head_ff[sidx]  <= '0;
            tail_ff[sidx]  <= '0;
            count_ff[sidx] <= '0;
         end
      end
   end

endmodule

### rtl/mmq_msg_store.sv
// Message memory with one write port and one registered read port.
// Depends on nothing beyond its parameters.
module mmq_msg_store #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 108,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [IDX_W-1:0] wr_idx,
   input  logic [WIDTH-1:0] wr_word,
   input  logic             rd_en,
   input  logic [IDX_W-1:0] rd_idx,
   output logic [WIDTH-1:0] rd_word
);

   logic [WIDTH-1:0] msg_mem [DEPTH];
   logic [WIDTH-1:0] rd_word_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         msg_mem[wr_idx] <= wr_word;
      end
      if (rd_en) begin
         rd_word_ff <= msg_mem[rd_idx];
      end
   end

   assign rd_word = rd_word_ff;

endmodule

### rtl/mmq_result.sv
// Final status selection and the response register.
// Depends on mmq_pkg.
module mmq_result #(
   parameter int PAYLOAD_BYTES = mmq_pkg::PAYLOAD_BYTES_DEF,
   localparam int DATA_W = 8 * PAYLOAD_BYTES,
   localparam int WORD_W = mmq_pkg::HDR_W + DATA_W
) (
   input  logic                clock,
   input  logic                load,
   input  mmq_pkg::mmq_op_type op,
   input  logic [WORD_W-1:0]   rd_word,
   input  logic [31:0]         wakeup_type,
   output logic [2:0]          status,
   output logic [7:0]          out_sender,
   output logic [31:0]         out_type,
   output logic [3:0]          out_size,
   output logic [63:0]         out_payload,
   output logic                notify
);

   mmq_pkg::mmq_status_type status_ff;
   mmq_pkg::mmq_status_type status_in;
   logic [7:0]  sender_ff;
   logic [31:0] type_ff;
   logic [3:0]  size_ff;
   logic [63:0] payload_ff;
   logic        notify_ff;

   logic [mmq_pkg::HDR_W-1:0] hdr;
   logic [31:0]               rd_type;

   assign hdr     = rd_word[DATA_W +: mmq_pkg::HDR_W];
   assign rd_type = hdr[35:4];

   always_comb begin
      status_in = op.status;
      if (op.pop && (rd_type == wakeup_type)) begin
         status_in = mmq_pkg::ST_WOKEN;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= status_in;
         notify_ff  <= op.notify;
         sender_ff  <= op.pop ? hdr[43:36] : 8'h00;
         type_ff    <= op.pop ? rd_type : 32'h0;
         size_ff    <= op.pop ? hdr[3:0] : 4'h0;
         payload_ff <= op.pop ? 64'(rd_word[DATA_W-1:0]) : 64'h0;
      end
   end

   assign status      = status_ff;
   assign out_sender  = sender_ff;
   assign out_type    = type_ff;
   assign out_size    = size_ff;
   assign out_payload = payload_ff;
   assign notify      = notify_ff;

endmodule

### rtl/multi_mailbox_message_queue_unit.sv
// Each request transfer performs one send, receive, wakeup or clear on one mailbox
// ring and yields exactly one response transfer. The block is a three-stage pipeline
// (request register, pointer update with message memory access, response register),
// and one request is accepted every cycle while responses are taken. Ring pointers
// clear at reset; message memory contents are undefined until written, so no clearing
// pass is needed. The user must write the wakeup type register only while the block
// is idle; the block itself does not enforce this.
module multi_mailbox_message_queue_unit #(
   parameter int MAILBOXES     = mmq_pkg::MAILBOXES_DEF,
   parameter int QUEUE_DEPTH   = mmq_pkg::QUEUE_DEPTH_DEF,
   parameter int PAYLOAD_BYTES = mmq_pkg::PAYLOAD_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   mmq_req_if.sink           req_ch,
   mmq_rsp_if.source         rsp_ch,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   localparam int STORE_D = MAILBOXES * QUEUE_DEPTH;
   localparam int IDX_W   = (STORE_D > 1) ? $clog2(STORE_D) : 1;
   localparam int WORD_W  = mmq_pkg::HDR_W + 8 * PAYLOAD_BYTES;

   logic                 s1_valid_ff, s1_valid_in;
   logic                 s2_valid_ff, s2_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          wakeup_type_ff;
   mmq_pkg::mmq_item_type s1_item_ff;
   mmq_pkg::mmq_op_type  s2_op_ff;

   mmq_pkg::mmq_op_type  op;
   logic [IDX_W-1:0]     wr_idx;
   logic [IDX_W-1:0]     rd_idx;
   logic [WORD_W-1:0]    wr_word;
   logic [WORD_W-1:0]    rd_word;

   logic req_fire, s1_go, s2_go, s2_free, out_free;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign s2_go    = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || s2_go;
   assign s1_go    = s1_valid_ff && s2_free;
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign req_fire = req_ch.valid && req_ch.ready;

   assign s1_valid_in  = req_fire || (s1_valid_ff && !s1_go);
   assign s2_valid_in  = s1_go || (s2_valid_ff && !s2_go);
   assign rsp_valid_in = s2_go || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         wakeup_type_ff <= 32'h0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            wakeup_type_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= '{func:                req_ch.func,
                         mailbox_slot:        req_ch.mailbox_slot,
                         sender_id:           req_ch.sender_id,
                         msg_type:            req_ch.msg_type,
                         msg_size:            req_ch.msg_size,
                         payload:             req_ch.payload,
                         target_blocked:      req_ch.target_blocked,
                         receiver_terminated: req_ch.receiver_terminated};
      end
      if (s1_go) begin
         s2_op_ff <= op;
      end
   end

   mmq_ctrl #(
      .MAILBOXES     (MAILBOXES),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .go          (s1_go),
      .item        (s1_item_ff),
      .wakeup_type (wakeup_type_ff),
      .op          (op),
      .wr_idx      (wr_idx),
      .rd_idx      (rd_idx),
      .wr_word     (wr_word)
   );

   mmq_msg_store #(
      .DEPTH (STORE_D),
      .WIDTH (WORD_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (s1_go && op.push),
      .wr_idx  (wr_idx),
      .wr_word (wr_word),
      .rd_en   (s1_go && op.pop),
      .rd_idx  (rd_idx),
      .rd_word (rd_word)
   );

   mmq_result #(
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_result (
      .clock       (clock),
      .load        (s2_go),
      .op          (s2_op_ff),
      .rd_word     (rd_word),
      .wakeup_type (wakeup_type_ff),
      .status      (rsp_ch.status),
      .out_sender  (rsp_ch.out_sender),
      .out_type    (rsp_ch.out_type),
      .out_size    (rsp_ch.out_size),
      .out_payload (rsp_ch.out_payload),
      .notify      (rsp_ch.notify)
   );

   assign rsp_ch.valid = rsp_valid_ff;

endmodule

### rtl/mmq_checker.sv
// Port-level checks on the response channel of the message queue, and their binding.
// Depends on mmq_pkg and on multi_mailbox_message_queue_unit.
module mmq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [7:0]  rsp_out_sender,
   input logic [31:0] rsp_out_type,
   input logic [3:0]  rsp_out_size,
   input logic [63:0] rsp_out_payload,
   input logic        rsp_notify
);

   logic popped;

   assign popped = (rsp_status == mmq_pkg::ST_OK) || (rsp_status == mmq_pkg::ST_WOKEN);

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_notify_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_notify |-> rsp_status == mmq_pkg::ST_OK)
      else $error("notify on a failed transfer");

   a_fields_zero_unless_popped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !popped |-> rsp_out_sender == 8'h00 && rsp_out_type == 32'h0 &&
                               rsp_out_size == 4'h0 && rsp_out_payload == 64'h0)
      else $error("message fields set without a pop");

   a_size_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_size <= 4'd8)
      else $error("popped size out of range");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_out_payload) && $stable(rsp_notify))
      else $error("stalled response changed");

endmodule

bind multi_mailbox_message_queue_unit mmq_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_status      (rsp_ch.status),
   .rsp_out_sender  (rsp_ch.out_sender),
   .rsp_out_type    (rsp_ch.out_type),
   .rsp_out_size    (rsp_ch.out_size),
   .rsp_out_payload (rsp_ch.out_payload),
   .rsp_notify      (rsp_ch.notify)
);

### test/multi_mailbox_message_queue_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for multi_mailbox_message_queue_unit: a directed table, then random traffic
// under several wakeup type settings, every response checked against an in-bench mailbox model
// or a fixed table status. Depends on mmq_pkg, mmq_req_if, mmq_rsp_if and the unit itself.
module multi_mailbox_message_queue_unit_test;

   localparam int MAILBOXES      = mmq_pkg::MAILBOXES_DEF;
   localparam int QUEUE_DEPTH    = mmq_pkg::QUEUE_DEPTH_DEF;
   localparam int PAYLOAD_BYTES  = mmq_pkg::PAYLOAD_BYTES_DEF;
   localparam int STORE_DEPTH    = MAILBOXES * QUEUE_DEPTH;
   localparam int PTR_W          = $clog2(QUEUE_DEPTH);
   localparam int FILL_W         = $clog2(QUEUE_DEPTH + 1);
   localparam int ITEMS_PER_PASS = 150;
   localparam int DRAIN_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct packed {
      mmq_pkg::mmq_status_type status;
      logic [7:0]     sender;
      logic [31:0]    msg_type;
      logic [3:0]     size;
      logic [63:0]    payload;
      logic           notify;
   } mailbox_reply_type;

   typedef struct {
      bit                      fixed;
      mmq_pkg::mmq_status_type status;
   } given_status_type;

   typedef struct {
      mmq_pkg::mmq_item_type   item;
      int                      reps;
      bit                      fixed;
      mmq_pkg::mmq_status_type status;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   logic        calm = 1'b0;

   mmq_req_if req_ch ();
   mmq_rsp_if rsp_ch ();

   multi_mailbox_message_queue_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   logic [PTR_W-1:0]  head_ptr     [MAILBOXES];
   logic [PTR_W-1:0]  tail_ptr     [MAILBOXES];
   logic [FILL_W-1:0] fill_cnt     [MAILBOXES];
   logic [7:0]        kept_sender  [STORE_DEPTH];
   logic [31:0]       kept_type    [STORE_DEPTH];
   logic [3:0]        kept_size    [STORE_DEPTH];
   logic [63:0]       kept_payload [STORE_DEPTH];
   logic [31:0]       wakeup_cfg;

   mailbox_reply_type pending_replies [$];
   given_status_type  given_status_q  [$];
   table_row_type     directed_rows   [$];

   int unsigned failures = 0;
   int unsigned requests_seen = 0;
   int unsigned responses_seen = 0;
   int unsigned directed_count = 0;
   int unsigned settings_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned stall_left = 0;
   int unsigned status_seen [8];

   always #5 clock = ~clock;

   function automatic int pick_idle();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == QUEUE_DEPTH - 1) ? '0 : ptr + 1'b1;
   endfunction

   function automatic bit push_message(input int unsigned slot, input logic [7:0] sender,
                                       input logic [31:0] mtype, input logic [3:0] size,
                                       input logic [63:0] data);
      int unsigned idx;
      if (fill_cnt[slot] == QUEUE_DEPTH) return 1'b0;
      idx = slot * QUEUE_DEPTH + tail_ptr[slot];
      kept_sender[idx]  = sender;
      kept_type[idx]    = mtype;
      kept_size[idx]    = size;
      kept_payload[idx] = data;
      tail_ptr[slot] = next_ptr(tail_ptr[slot]);
      fill_cnt[slot] = fill_cnt[slot] + 1'b1;
      return 1'b1;
   endfunction

   function automatic mailbox_reply_type apply_mailbox_op(input mmq_pkg::mmq_item_type it);
      mailbox_reply_type r;
      int unsigned       slot;
      int unsigned       idx;
      logic [63:0]       keep;
      r = '0;
      r.status = mmq_pkg::ST_OK;
      slot = 32'(it.mailbox_slot);
      if (slot >= MAILBOXES) begin
         r.status = mmq_pkg::ST_BAD_SLOT;
      end else begin
         case (it.func)
            mmq_pkg::FUNC_SEND: begin
               keep = (it.msg_size >= 8) ? '1 : ((64'd1 << (8 * it.msg_size)) - 64'd1);
               if (it.msg_size > PAYLOAD_BYTES) begin
                  r.status = mmq_pkg::ST_TOO_LARGE;
               end else if (!push_message(slot, it.sender_id, it.msg_type, it.msg_size[3:0],
                                          it.payload & keep)) begin
                  r.status = mmq_pkg::ST_FULL;
               end else begin
                  r.notify = it.target_blocked;
               end
            end
            mmq_pkg::FUNC_RECEIVE: begin
               if (it.receiver_terminated) begin
                  r.status = mmq_pkg::ST_TERMINATED;
               end else if (fill_cnt[slot] == 0) begin
                  r.status = mmq_pkg::ST_EMPTY;
               end else begin
                  idx = slot * QUEUE_DEPTH + head_ptr[slot];
                  r.sender   = kept_sender[idx];
                  r.msg_type = kept_type[idx];
                  r.size     = kept_size[idx];
                  r.payload  = kept_payload[idx];
                  head_ptr[slot] = next_ptr(head_ptr[slot]);
                  fill_cnt[slot] = fill_cnt[slot] - 1'b1;
                  r.status = (r.msg_type == wakeup_cfg) ? mmq_pkg::ST_WOKEN : mmq_pkg::ST_OK;
               end
            end
            mmq_pkg::FUNC_WAKEUP: begin
               if (!push_message(slot, 8'h00, wakeup_cfg, 4'd0, 64'h0)) begin
                  r.status = mmq_pkg::ST_FULL;
               end else begin
                  r.notify = it.target_blocked;
               end
            end
            mmq_pkg::FUNC_CLEAR: begin
               head_ptr[slot] = '0;
               tail_ptr[slot] = '0;
               fill_cnt[slot] = '0;
            end
         endcase
      end
      return r;
   endfunction

   function automatic mmq_pkg::mmq_item_type random_item(input int push_pct);
      mmq_pkg::mmq_item_type it;
      int r;
      r = $urandom_range(99);
      if (r < 5) it.func = mmq_pkg::FUNC_CLEAR;
      else if (r < 5 + push_pct * 3 / 4) it.func = mmq_pkg::FUNC_SEND;
      else if (r < 5 + push_pct) it.func = mmq_pkg::FUNC_WAKEUP;
      else it.func = mmq_pkg::FUNC_RECEIVE;
      r = $urandom_range(99);
      if (r < 4) it.mailbox_slot = 8'($urandom_range(255, MAILBOXES));
      else if (r < 14) it.mailbox_slot = 8'($urandom_range(MAILBOXES - 1, 0));
      else it.mailbox_slot = 8'($urandom_range(3, 0));
      it.sender_id = 8'($urandom_range(255, 0));
      it.msg_type = ($urandom_range(99) < 25) ? wakeup_cfg : $urandom;
      it.msg_size = ($urandom_range(99) < 90) ? 8'($urandom_range(PAYLOAD_BYTES, 0))
                                               : 8'($urandom_range(255, PAYLOAD_BYTES + 1));
      it.payload = {$urandom, $urandom};
      it.target_blocked = 1'($urandom_range(1, 0));
      it.receiver_terminated = ($urandom_range(99) < 8);
      return it;
   endfunction

   task automatic add_row(input mmq_pkg::mmq_func_type f, input logic [7:0] slot,
                          input logic [7:0] sender, input logic [31:0] mtype,
                          input logic [7:0] size, input logic [63:0] data,
                          input logic blocked, input logic term, input int reps,
                          input bit fixed, input mmq_pkg::mmq_status_type st);
      table_row_type row;
      row.item.func = f;
      row.item.mailbox_slot = slot;
      row.item.sender_id = sender;
      row.item.msg_type = mtype;
      row.item.msg_size = size;
      row.item.payload = data;
      row.item.target_blocked = blocked;
      row.item.receiver_terminated = term;
      row.reps = reps;
      row.fixed = fixed;
      row.status = st;
      directed_rows.push_back(row);
   endtask

   task automatic report_mismatch(input string what);
      failures++;
      $display("Mismatch at %0t ns: %s", $time, what);
   endtask

   // Leaves valid high after the accepting edge so back-to-back transfers need no second write.
   task automatic drive_request(input mmq_pkg::mmq_item_type it, input bit fixed,
                                input mmq_pkg::mmq_status_type st);
      given_status_type g;
      int gap;
      gap = calm ? 0 : pick_idle();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      g.fixed = fixed;
      g.status = st;
      given_status_q.push_back(g);
      req_ch.valid <= 1'b1;
      req_ch.func <= it.func;
      req_ch.mailbox_slot <= it.mailbox_slot;
      req_ch.sender_id <= it.sender_id;
      req_ch.msg_type <= it.msg_type;
      req_ch.msg_size <= it.msg_size;
      req_ch.payload <= it.payload;
      req_ch.target_blocked <= it.target_blocked;
      req_ch.receiver_terminated <= it.receiver_terminated;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_wakeup_type(input logic [31:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wakeup_cfg = value;
      settings_count++;
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (!calm) stall_left <= pick_idle();
      end
   end

   always @(posedge clock) begin : checker_proc
      mmq_pkg::mmq_item_type seen_item;
      mailbox_reply_type     want;
      given_status_type      given;
      bit                    moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            requests_seen++;
            seen_item.func = req_ch.func;
            seen_item.mailbox_slot = req_ch.mailbox_slot;
            seen_item.sender_id = req_ch.sender_id;
            seen_item.msg_type = req_ch.msg_type;
            seen_item.msg_size = req_ch.msg_size;
            seen_item.payload = req_ch.payload;
            seen_item.target_blocked = req_ch.target_blocked;
            seen_item.receiver_terminated = req_ch.receiver_terminated;
            given = given_status_q.pop_front();
            want = apply_mailbox_op(seen_item);
            if (given.fixed) begin
               want = '0;
               want.status = given.status;
            end
            pending_replies.push_back(want);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            responses_seen++;
            status_seen[rsp_ch.status]++;
            if (pending_replies.size() == 0) begin
               report_mismatch("response transfer with no request outstanding");
            end else begin
               want = pending_replies.pop_front();
               if (rsp_ch.status !== want.status || rsp_ch.out_sender !== want.sender ||
                   rsp_ch.out_type !== want.msg_type || rsp_ch.out_size !== want.size ||
                   rsp_ch.out_payload !== want.payload || rsp_ch.notify !== want.notify)
                  report_mismatch($sformatf(
                     "got %0d/%02h/%08h/%0d/%016h/%0b, expected %0d/%02h/%08h/%0d/%016h/%0b",
                     rsp_ch.status, rsp_ch.out_sender, rsp_ch.out_type, rsp_ch.out_size,
                     rsp_ch.out_payload, rsp_ch.notify, want.status, want.sender,
                     want.msg_type, want.size, want.payload, want.notify));
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("No transfer for %0d cycles, %0d responses outstanding.",
                     idle_cycles, pending_replies.size());
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      logic [31:0] pass_wakeup [4];
      int          pass_push [4];
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_ch.valid <= 1'b0;
      req_ch.func <= mmq_pkg::FUNC_SEND;
      req_ch.mailbox_slot <= '0;
      req_ch.sender_id <= '0;
      req_ch.msg_type <= '0;
      req_ch.msg_size <= '0;
      req_ch.payload <= '0;
      req_ch.target_blocked <= 1'b0;
      req_ch.receiver_terminated <= 1'b0;
      wakeup_cfg = '0;
      for (int i = 0; i < MAILBOXES; i++) begin
         head_ptr[i] = '0;
         tail_ptr[i] = '0;
         fill_cnt[i] = '0;
      end
      foreach (status_seen[i]) status_seen[i] = 0;

      add_row(mmq_pkg::FUNC_RECEIVE, 8'd0, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b0,
              1, 1'b1, mmq_pkg::ST_EMPTY);
      add_row(mmq_pkg::FUNC_RECEIVE, 8'd15, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b1,
              1, 1'b1, mmq_pkg::ST_TERMINATED);
      add_row(mmq_pkg::FUNC_SEND, 8'd16, 8'h11, 32'h1, 8'd1, 64'hFF, 1'b1, 1'b0,
              1, 1'b1, mmq_pkg::ST_BAD_SLOT);
      add_row(mmq_pkg::FUNC_RECEIVE, 8'd255, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b0,
              1, 1'b1, mmq_pkg::ST_BAD_SLOT);
      add_row(mmq_pkg::FUNC_WAKEUP, 8'd128, 8'h00, 32'h0, 8'd0, 64'h0, 1'b1, 1'b0,
              1, 1'b1, mmq_pkg::ST_BAD_SLOT);
      add_row(mmq_pkg::FUNC_CLEAR, 8'd200, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b0,
              1, 1'b1, mmq_pkg::ST_BAD_SLOT);
      add_row(mmq_pkg::FUNC_SEND, 8'd0, 8'h22, 32'h5, 8'd9, '1, 1'b1, 1'b0,
              1, 1'b1, mmq_pkg::ST_TOO_LARGE);
      add_row(mmq_pkg::FUNC_SEND, 8'd0, 8'h22, 32'h5, 8'd255, '1, 1'b1, 1'b0,
              1, 1'b1, mmq_pkg::ST_TOO_LARGE);
      add_row(mmq_pkg::FUNC_SEND, 8'd0, 8'hFF, 32'hFFFF_FFFF, 8'd8, '1, 1'b1, 1'b0,
              1, 1'b0, mmq_pkg::ST_OK);
      add_row(mmq_pkg::FUNC_SEND, 8'd0, 8'h00, 32'h0, 8'd0, '1, 1'b0, 1'b0,
              1, 1'b0, mmq_pkg::ST_OK);
      add_row(mmq_pkg::FUNC_SEND, 8'd0, 8'h5A, 32'h1234_5678, 8'd3, 64'h0123_4567_89AB_CDEF,
              1'b1, 1'b0, 1, 1'b0, mmq_pkg::ST_OK);
      add_row(mmq_pkg::FUNC_WAKEUP, 8'd0, 8'h77, 32'hDEAD_BEEF, 8'd5, '1, 1'b1, 1'b0,
              1, 1'b0, mmq_pkg::ST_OK);
      add_row(mmq_pkg::FUNC_RECEIVE, 8'd0, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b1,
              1, 1'b1, mmq_pkg::ST_TERMINATED);
      add_row(mmq_pkg::FUNC_RECEIVE, 8'd0, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b0,
              4, 1'b0, mmq_pkg::ST_OK);
      add_row(mmq_pkg::FUNC_RECEIVE, 8'd0, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b0,
              1, 1'b1, mmq_pkg::ST_EMPTY);
      add_row(mmq_pkg::FUNC_WAKEUP, 8'd15, 8'h00, 32'h0, 8'd0, 64'h0, 1'b1, 1'b0,
              QUEUE_DEPTH, 1'b0, mmq_pkg::ST_OK);
      add_row(mmq_pkg::FUNC_WAKEUP, 8'd15, 8'h00, 32'h0, 8'd0, 64'h0, 1'b1, 1'b0,
              1, 1'b1, mmq_pkg::ST_FULL);
      add_row(mmq_pkg::FUNC_SEND, 8'd15, 8'h33, 32'h9, 8'd8, '1, 1'b1, 1'b0,
              1, 1'b1, mmq_pkg::ST_FULL);
      add_row(mmq_pkg::FUNC_CLEAR, 8'd15, 8'h00, 32'h0, 8'd0, 64'h0, 1'b1, 1'b0,
              1, 1'b1, mmq_pkg::ST_OK);
      add_row(mmq_pkg::FUNC_RECEIVE, 8'd15, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b0,
              1, 1'b1, mmq_pkg::ST_EMPTY);
      add_row(mmq_pkg::FUNC_SEND, 8'd15, 8'h01, 32'hA5A5_5A5A, 8'd4, 64'hFEDC_BA98_7654_3210,
              1'b0, 1'b0, 1, 1'b0, mmq_pkg::ST_OK);
      add_row(mmq_pkg::FUNC_RECEIVE, 8'd15, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b0,
              1, 1'b0, mmq_pkg::ST_OK);
      add_row(mmq_pkg::FUNC_CLEAR, 8'd0, 8'h00, 32'h0, 8'd0, 64'h0, 1'b0, 1'b0,
              1, 1'b1, mmq_pkg::ST_OK);

      pass_wakeup[0] = 32'hFFFF_FFFF;
      pass_wakeup[1] = $urandom;
      pass_wakeup[2] = 32'h0000_0000;
      pass_wakeup[3] = $urandom;
      pass_push[0] = 70;
      pass_push[1] = 30;
      pass_push[2] = 50;
      pass_push[3] = 45;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         repeat (directed_rows[i].reps) begin
            drive_request(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].status);
            directed_count++;
         end
      end

      for (int p = 0; p < 4; p++) begin
         set_wakeup_type(pass_wakeup[p]);
         calm = (p == 2);
         repeat (ITEMS_PER_PASS) drive_request(random_item(pass_push[p]), 1'b0, mmq_pkg::ST_OK);
         calm = 1'b0;
      end

      wait_idle();
      $display("Covered %0d directed and %0d random requests, %0d responses, %0d wakeup types.",
               directed_count, requests_seen - directed_count, responses_seen, settings_count);
      $display("Statuses ok/bad slot/too large/full/empty/woken/terminated: %0d/%0d/%0d/%0d/%0d/%0d/%0d.",
               status_seen[mmq_pkg::ST_OK], status_seen[mmq_pkg::ST_BAD_SLOT],
               status_seen[mmq_pkg::ST_TOO_LARGE], status_seen[mmq_pkg::ST_FULL],
               status_seen[mmq_pkg::ST_EMPTY], status_seen[mmq_pkg::ST_WOKEN],
               status_seen[mmq_pkg::ST_TERMINATED]);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/mmq_pkg.sv
rtl/mmq_if.sv
rtl/mmq_ctrl.sv
rtl/mmq_msg_store.sv
rtl/mmq_result.sv
rtl/multi_mailbox_message_queue_unit.sv
rtl/mmq_checker.sv
test/multi_mailbox_message_queue_unit_test.sv
